// ----- rtl/prc_pkg.sv -----
// Shared types and constants for the prefix route classifier.
// Used by every module under rtl; depends on nothing else.
package prc_pkg;

    localparam int ROUTE_COUNT    = 3;
    localparam int ADDR_W         = 32;
    localparam int PREFIX_W       = 6;
    localparam int HOP_W          = 8;
    localparam int TALLY_W        = 5;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 32;
    localparam int BATCH_SIZE_DEF = 20;

    localparam logic [TALLY_W-1:0]  TALLY_MAX  = 5'd31;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;
    localparam logic [HOP_W-1:0]    HOP_EXPIRE = 8'd1;

    typedef enum logic [2:0] {
        VERDICT_EXPIRED    = 3'd0,
        VERDICT_FWD_B      = 3'd1,
        VERDICT_DELIVERED  = 3'd2,
        VERDICT_FWD_C      = 3'd3,
        VERDICT_UNROUTABLE = 3'd4
    } verdict_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROUTE_B_ADDR       = 3'd0,
        REG_ROUTE_B_PREFIX     = 3'd1,
        REG_ROUTE_LOCAL_ADDR   = 3'd2,
        REG_ROUTE_LOCAL_PREFIX = 3'd3,
        REG_ROUTE_C_ADDR       = 3'd4,
        REG_ROUTE_C_PREFIX     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [PREFIX_W-1:0] prefix;
    } route_t;

    typedef struct packed {
        logic [TALLY_W-1:0] expired;
        logic [TALLY_W-1:0] unroutable;
        logic [TALLY_W-1:0] delivered;
        logic [TALLY_W-1:0] fwd_b;
        logic [TALLY_W-1:0] fwd_c;
    } tally_t;

endpackage

// ----- rtl/prc_cfg_regs.sv -----
// Route configuration registers of the prefix route classifier.
// Depends on prc_pkg.
module prc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [prc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output prc_pkg::route_t                  routes [prc_pkg::ROUTE_COUNT]
);
    import prc_pkg::*;

    route_t route_b_reg;
    route_t route_local_reg;
    route_t route_c_reg;

    // Writes to indexes beyond the register list fall into the default arm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_b_reg     <= '0;
            route_local_reg <= '0;
            route_c_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROUTE_B_ADDR:       route_b_reg.addr       <= cfg_data[ADDR_W-1:0];
                REG_ROUTE_B_PREFIX:     route_b_reg.prefix     <= cfg_data[PREFIX_W-1:0];
                REG_ROUTE_LOCAL_ADDR:   route_local_reg.addr   <= cfg_data[ADDR_W-1:0];
                REG_ROUTE_LOCAL_PREFIX: route_local_reg.prefix <= cfg_data[PREFIX_W-1:0];
                REG_ROUTE_C_ADDR:       route_c_reg.addr       <= cfg_data[ADDR_W-1:0];
                REG_ROUTE_C_PREFIX:     route_c_reg.prefix     <= cfg_data[PREFIX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign routes[0] = route_b_reg;
    assign routes[1] = route_local_reg;
    assign routes[2] = route_c_reg;

endmodule

// ----- rtl/prc_route_match.sv -----
// Prefix compare of one address against one configured route.
// Depends on prc_pkg.
module prc_route_match (
    input  logic [prc_pkg::ADDR_W-1:0] addr,
    input  prc_pkg::route_t            route,
    output logic                       match
);
    import prc_pkg::*;

    logic [PREFIX_W-1:0] plen;
    logic [ADDR_W-1:0]   mask;

    // Prefix lengths above 32 compare all bits; a zero prefix compares none.
    assign plen = (route.prefix > PREFIX_MAX) ? PREFIX_MAX : route.prefix;

    always_comb
    begin
        for (int i = 0; i < ADDR_W; i++)
        begin
            mask[i] = ({1'b0, i[PREFIX_W-1:0]} + {1'b0, plen}) >= (PREFIX_W + 1)'(ADDR_W);
        end
    end

    assign match = ((addr ^ route.addr) & mask) == '0;

endmodule

// ----- rtl/prc_tally.sv -----
// Batch outcome counters and batch position of the prefix route classifier.
// Depends on prc_pkg.
module prc_tally #(
    parameter int  BATCH_SIZE = prc_pkg::BATCH_SIZE_DEF,
    localparam int POS_W      = $clog2(BATCH_SIZE + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  prc_pkg::verdict_t verdict,
    output prc_pkg::tally_t   counts_next,
    output logic              batch_end_next,
    output logic [POS_W-1:0]  batch_pos
);
    import prc_pkg::*;

    tally_t            tally_reg;
    logic [POS_W-1:0]  pos_reg;

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
        return (v == TALLY_MAX) ? v : v + 1'b1;
    endfunction

    // Counts as they stand after the current item, which the result carries.
    always_comb
    begin
        counts_next = tally_reg;
        case (verdict)
            VERDICT_EXPIRED:    counts_next.expired    = bump(tally_reg.expired);
            VERDICT_FWD_B:      counts_next.fwd_b      = bump(tally_reg.fwd_b);
            VERDICT_DELIVERED:  counts_next.delivered  = bump(tally_reg.delivered);
            VERDICT_FWD_C:      counts_next.fwd_c      = bump(tally_reg.fwd_c);
            default:            counts_next.unroutable = bump(tally_reg.unroutable);
        endcase
    end

    assign batch_end_next = (pos_reg == POS_W'(BATCH_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            if (batch_end_next)
            begin
                tally_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                tally_reg <= counts_next;
                pos_reg   <= pos_reg + 1'b1;
            end
        end
    end

    assign batch_pos = pos_reg;

endmodule

// ----- rtl/prefix_route_classifier_top.sv -----
// Top level of the prefix route classifier: input register, route compares,
// batch counters and result register. Depends on prc_pkg and all prc_ modules.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: dest_addr[31:0], hop_limit[39:32]
// m_       out  m_tvalid/m_tready  m_tdata: verdict, five counts; m_tlast: batch_end
// cfg_     in   cfg_we (no wait)   cfg_index selects the register, cfg_data holds it
//
// An item passes from the input register to the result register, and a new
// item is taken every cycle while m_tready stays high. The route compares and
// the counter update sit between the two registers. A stall on m_tready holds
// the result register; the input register still takes an item while it is
// empty, and s_tready drops once both registers are full. Reset clears the
// routes, counters and both valid flags.
module prefix_route_classifier_top #(
    parameter int BATCH_SIZE = prc_pkg::BATCH_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dest_addr [31:0], hop_limit [39:32]
    input  logic [prc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // verdict [2:0], expired_count [7:3], unroutable_count [12:8],
    // delivered_count [17:13], fwd_b_count [22:18], fwd_c_count [27:23], zeros above
    output logic [prc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [prc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import prc_pkg::*;

    localparam int POS_W = $clog2(BATCH_SIZE + 1);

    route_t              routes [ROUTE_COUNT];
    logic                in_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [HOP_W-1:0]    hop_reg;
    logic                out_valid_reg;
    verdict_t            verdict_reg;
    tally_t              counts_reg;
    logic                last_reg;
    logic                advance;
    logic [ROUTE_COUNT-1:0] match;
    verdict_t            verdict;
    tally_t              counts_next;
    logic                batch_end_next;
    logic [POS_W-1:0]    batch_pos;

    prc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .routes    (routes)
    );

    // The item in the input register moves on when the result register is
    // free or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            addr_reg <= s_tdata[ADDR_W-1:0];
            hop_reg  <= s_tdata[ADDR_W +: HOP_W];
        end
    end

    for (genvar r = 0; r < ROUTE_COUNT; r++)
    begin : g_match
        prc_route_match u_match (
            .addr  (addr_reg),
            .route (routes[r]),
            .match (match[r])
        );
    end

    // Expiry wins over every route; routes then take priority in list order.
    always_comb
    begin
        if (hop_reg <= HOP_EXPIRE)
        begin
            verdict = VERDICT_EXPIRED;
        end
        else if (match[0])
        begin
            verdict = VERDICT_FWD_B;
        end
        else if (match[1])
        begin
            verdict = VERDICT_DELIVERED;
        end
        else if (match[2])
        begin
            verdict = VERDICT_FWD_C;
        end
        else
        begin
            verdict = VERDICT_UNROUTABLE;
        end
    end

    prc_tally #(
        .BATCH_SIZE (BATCH_SIZE)
    ) u_tally (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .verdict        (verdict),
        .counts_next    (counts_next),
        .batch_end_next (batch_end_next),
        .batch_pos      (batch_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg <= verdict;
            counts_reg  <= counts_next;
            last_reg    <= batch_end_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000,
                       counts_reg.fwd_c,
                       counts_reg.fwd_b,
                       counts_reg.delivered,
                       counts_reg.unroutable,
                       counts_reg.expired,
                       verdict_reg};

    // A result that closes a batch has already cleared the batch position.
    a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (batch_pos == '0))
        else $error("batch position not cleared behind a batch end");

    // The input side only stalls with both registers full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // A result always counts itself in the tally for its own verdict.
    a_verdict_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((verdict_reg == VERDICT_EXPIRED    && counts_reg.expired    != '0) ||
             (verdict_reg == VERDICT_FWD_B      && counts_reg.fwd_b      != '0) ||
             (verdict_reg == VERDICT_DELIVERED  && counts_reg.delivered  != '0) ||
             (verdict_reg == VERDICT_FWD_C      && counts_reg.fwd_c      != '0) ||
             (verdict_reg == VERDICT_UNROUTABLE && counts_reg.unroutable != '0)))
        else $error("result verdict missing from its tally");

endmodule

// ----- tb/sv/tb_prefix_route_classifier_top.sv -----
// Self-checking testbench for prefix_route_classifier_top: drives packets on the
// input stream, predicts each verdict and the batch counters, checks every result.
// Depends on prc_pkg and the classifier RTL only.
module tb_prefix_route_classifier_top;

    import prc_pkg::*;

    // This bound on the run only catches a hang.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int PACKETS_PER_PHASE = 175;
    // Register indexes past the last route register; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // One expected result: the verdict, the five batch tallies and the batch end flag.
    typedef struct {
        verdict_t verdict;
        tally_t   counts;
        logic     batch_end;
    } packet_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // dest_addr [31:0], hop_limit [39:32]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // verdict [2:0], expired [7:3], unroutable [12:8], delivered [17:13],
    // fwd_b [22:18], fwd_c [27:23], zeros above
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the block: route table, batch tallies and position in the batch.
    route_t routes [ROUTE_COUNT];
    tally_t tallies;
    int     batch_pos;

    packet_result_t pending_verdicts [$];
    int             error_count = 0;
    int             cycle_count = 0;
    // When set, neither the sender nor the receiver inserts idle cycles.
    bit             steady = 1'b0;
    // Cycles the receiver still holds m_tready low before taking the next result.
    int             rx_wait = 0;

    prefix_route_classifier_top #(
        .BATCH_SIZE (BATCH_SIZE_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Mask of the top prefix bits. Lengths above 32 saturate to a full compare,
    // and a zero length compares nothing, so that route catches every address.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
        int p;
        p = (plen > PREFIX_MAX) ? 32 : int'(plen);
        if (p == 0)
            return '0;
        return 32'hFFFF_FFFF << (32 - p);
    endfunction

    function automatic bit route_hit(input logic [ADDR_W-1:0] addr, input route_t rt);
        return ((addr ^ rt.addr) & prefix_mask(rt.prefix)) == '0;
    endfunction

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
        return (v < TALLY_MAX) ? v + 1'b1 : TALLY_MAX;
    endfunction

    // Mirrors a register write into the shadow route table.
    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_ROUTE_B_ADDR:       routes[0].addr   = data;
            REG_ROUTE_B_PREFIX:     routes[0].prefix = data[PREFIX_W-1:0];
            REG_ROUTE_LOCAL_ADDR:   routes[1].addr   = data;
            REG_ROUTE_LOCAL_PREFIX: routes[1].prefix = data[PREFIX_W-1:0];
            REG_ROUTE_C_ADDR:       routes[2].addr   = data;
            REG_ROUTE_C_PREFIX:     routes[2].prefix = data[PREFIX_W-1:0];
            default: ;
        endcase
    endfunction

    // Classifies one accepted packet and advances the batch tallies. Expiry wins
    // over every route; the routes are then tried in order B, local, C.
    function automatic packet_result_t classify_packet(input logic [ADDR_W-1:0] addr,
                                                       input logic [HOP_W-1:0] hop);
        packet_result_t r;
        if (hop <= HOP_EXPIRE)
        begin
            r.verdict = VERDICT_EXPIRED;
            tallies.expired = bump(tallies.expired);
        end
        else if (route_hit(addr, routes[0]))
        begin
            r.verdict = VERDICT_FWD_B;
            tallies.fwd_b = bump(tallies.fwd_b);
        end
        else if (route_hit(addr, routes[1]))
        begin
            r.verdict = VERDICT_DELIVERED;
            tallies.delivered = bump(tallies.delivered);
        end
        else if (route_hit(addr, routes[2]))
        begin
            r.verdict = VERDICT_FWD_C;
            tallies.fwd_c = bump(tallies.fwd_c);
        end
        else
        begin
            r.verdict = VERDICT_UNROUTABLE;
            tallies.unroutable = bump(tallies.unroutable);
        end
        batch_pos++;
        r.counts = tallies;
        r.batch_end = (batch_pos >= BATCH_SIZE_DEF);
        // The tallies reported with the last packet of a batch are the full
        // batch; the next packet starts from zero.
        if (r.batch_end)
        begin
            tallies = '0;
            batch_pos = 0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one packet on the input stream after a random gap and waits until
    // it is accepted. The expected result is queued at the accepting edge.
    task automatic send_packet(input logic [ADDR_W-1:0] addr, input logic [HOP_W-1:0] hop);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {hop, addr};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_verdicts.push_back(classify_packet(addr, hop));
    endtask

    // Stops the sender, waits until every queued result has been checked and then
    // lets the pipeline empty before the routes change.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Presents one register write; cfg_we stays high so back-to-back writes
    // need no lowering in between. The caller lowers it after the last write.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        apply_reg(index, data);
    endtask

    // Loads all three routes. Prefix writes carry random junk above bit 5 since
    // only the low six bits belong to the register. The spare indexes are
    // written as well and must leave the table untouched.
    task automatic program_routes(input logic [ADDR_W-1:0] b_addr, input int b_plen,
                                  input logic [ADDR_W-1:0] l_addr, input int l_plen,
                                  input logic [ADDR_W-1:0] c_addr, input int c_plen);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom & ~32'h3F;
        cfg_write(REG_ROUTE_B_ADDR, b_addr);
        cfg_write(REG_ROUTE_B_PREFIX, junk | b_plen[PREFIX_W-1:0]);
        cfg_write(REG_ROUTE_LOCAL_ADDR, l_addr);
        cfg_write(REG_ROUTE_LOCAL_PREFIX, junk | l_plen[PREFIX_W-1:0]);
        cfg_write(REG_ROUTE_C_ADDR, c_addr);
        cfg_write(REG_ROUTE_C_PREFIX, junk | c_plen[PREFIX_W-1:0]);
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_prefix();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 32;
            2:       return $urandom_range(33, 63);
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    // Mostly addresses inside one of the routes, sometimes with one random bit flipped,
    // which may land it just outside; the rest are uniform.
    function automatic logic [ADDR_W-1:0] pick_dest();
        logic [ADDR_W-1:0] m;
        logic [ADDR_W-1:0] a;
        int r;
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        r = $urandom_range(0, ROUTE_COUNT - 1);
        m = prefix_mask(routes[r].prefix);
        a = (routes[r].addr & m) | ($urandom & ~m);
        if ($urandom_range(0, 3) == 0)
            a[$urandom_range(0, 31)] ^= 1'b1;
        return a;
    endfunction

    function automatic logic [HOP_W-1:0] pick_hop();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset every route is 0/0, so route B catches all live packets and
    // only the hop limit can change the verdict.
    task automatic test_reset_routes();
        send_packet(32'h0000_0000, 8'd0);
        send_packet(32'hFFFF_FFFF, 8'd1);
        send_packet(32'h1234_5678, 8'd2);
        send_packet(32'hFFFF_FFFF, 8'd255);
    endtask

    // Overlapping routes checked in priority order, plus expiry on a matching
    // address and a packet that matches nothing.
    task automatic test_route_priority();
        wait_idle();
        program_routes(32'hC0A8_0100, 24, 32'hC0A8_0000, 16, 32'h0A00_0000, 8);
        send_packet(32'hC0A8_0105, 8'd64);
        send_packet(32'hC0A8_0205, 8'd2);
        send_packet(32'h0A12_3456, 8'd255);
        send_packet(32'h0B00_0000, 8'd3);
        send_packet(32'hC0A8_0101, 8'd1);
        send_packet(32'h0000_0000, 8'd0);
        send_packet(32'hFFFF_FFFF, 8'd128);
    endtask

    // Full-length prefixes, a length above 32 that must saturate, and a zero
    // length on route C that catches everything the others miss.
    task automatic test_prefix_extremes();
        wait_idle();
        program_routes(32'hFFFF_FFFF, 32, 32'h8000_0001, 63, 32'h0000_0000, 0);
        send_packet(32'hFFFF_FFFF, 8'd9);
        send_packet(32'hFFFF_FFFE, 8'd9);
        send_packet(32'h8000_0001, 8'd200);
        send_packet(32'h8000_0000, 8'd2);
        send_packet(32'h7FFF_FFFF, 8'd7);
        wait_idle();
        program_routes(32'h8000_0000, 1, 32'h0000_0000, 33, 32'h4000_0000, 2);
        send_packet(32'h8000_0000, 8'd5);
        send_packet(32'h0000_0000, 8'd5);
        send_packet(32'h4000_0001, 8'd5);
        send_packet(32'h2000_0000, 8'd5);
        send_packet(32'hFFFF_FFFF, 8'd0);
    endtask

    // Random route tables and traffic aimed at them. Every fourth phase runs
    // with no idle cycles on either side; each phase ends with the sender
    // holding off until all results are back.
    task automatic test_random_traffic();
        logic [ADDR_W-1:0] b_addr;
        logic [ADDR_W-1:0] l_addr;
        logic [ADDR_W-1:0] c_addr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            steady = (phase % 4 == 3);
            b_addr = $urandom;
            // Often let the routes share leading bits so priority matters.
            l_addr = $urandom_range(0, 1) ? (b_addr ^ ($urandom >> $urandom_range(4, 31)))
                                          : $urandom;
            c_addr = $urandom_range(0, 1) ? (l_addr ^ ($urandom >> $urandom_range(4, 31)))
                                          : $urandom;
            program_routes(b_addr, pick_prefix(), l_addr, pick_prefix(),
                           c_addr, pick_prefix());
            for (int n = 0; n < PACKETS_PER_PHASE; n++)
                send_packet(pick_dest(), pick_hop());
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Receiver back-pressure: m_tready drops for the number of cycles drawn
    // after each taken result, and stays high otherwise.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every taken result is compared with the oldest queued prediction.
    always @(posedge clk)
    begin
        packet_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_wait = steady ? 0 : $urandom_range(0, 7);
            if (pending_verdicts.size() == 0)
            begin
                $error("result item with no packet pending");
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("verdict", want.verdict, m_tdata[2:0]);
                check_field("expired_count", want.counts.expired, m_tdata[7:3]);
                check_field("unroutable_count", want.counts.unroutable, m_tdata[12:8]);
                check_field("delivered_count", want.counts.delivered, m_tdata[17:13]);
                check_field("fwd_b_count", want.counts.fwd_b, m_tdata[22:18]);
                check_field("fwd_c_count", want.counts.fwd_c, m_tdata[27:23]);
                check_field("batch_end", want.batch_end, m_tlast);
            end
        end
    end

    // Watchdog against a stalled handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_prefix_route_classifier_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int i = 0; i < ROUTE_COUNT; i++)
            routes[i] = '0;
        tallies   = '0;
        batch_pos = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_routes();
        test_route_priority();
        test_prefix_extremes();
        test_random_traffic();

        // Drain, then leave room for any stray result to show up.
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_prefix_route_classifier_top: clean");
        else
            $display("tb_prefix_route_classifier_top: errors");
        $finish;
    end

endmodule
